>>> rtl/ray_box_slab_test_unit_macros.svh
// Assertion macros for the ray box slab test unit.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RAY_BOX_SLAB_TEST_UNIT_MACROS_SVH
`define RAY_BOX_SLAB_TEST_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RBST_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbst: %s failed", "label");

// Check that the consequent holds in the cycle after the antecedent.
`define RBST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbst: %s failed", "label");

`endif

>>> rtl/rbst_pkg.sv
// Shared types and constants for the ray box slab test unit.
// No dependencies.
package rbst_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int NUM_AXES          = 3;
  localparam int NUM_LANES         = 2 * NUM_AXES;
  localparam int QUO_BITS          = 32;
  localparam int IN_BITS           = 12 * 32;
  localparam int OUT_BITS          = 72;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] low;
    logic [31:0] dvs;
    logic        ovf;
    logic        neg;
  } rbst_lane_t;

  typedef struct packed {
    logic [NUM_AXES-1:0] dzero;
    logic [NUM_AXES-1:0] in_slab;
  } rbst_meta_t;

  typedef rbst_lane_t [NUM_LANES-1:0] rbst_lanes_t;

endpackage

>>> rtl/rbst_front.sv
// Input stage: slab differences, magnitudes, overflow, zero-direction and in-slab flags.
// Depends on rbst_pkg.
module rbst_front import rbst_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [IN_BITS-1:0] data_i,
  output logic               valid_o,
  output rbst_lanes_t        lanes_o,
  output rbst_meta_t         meta_o
);

  localparam int NW = 33 + FRACTION_BITS;

  function automatic rbst_lane_t prep(logic signed [31:0] b, logic signed [31:0] o,
                                      logic signed [31:0] d);
    logic signed [32:0]   diff;
    logic [32:0]          mag;
    logic [NW-1:0]        num;
    logic [NW-33:0]       hi;
    rbst_lane_t           l;
    diff  = {b[31], b} - {o[31], o};
    mag   = diff[32] ? 33'(-diff) : 33'(diff);
    num   = {{FRACTION_BITS{1'b0}}, mag} << FRACTION_BITS;
    hi    = num[NW-1:32];
    l.dvs = d[31] ? 32'(-d) : 32'(d);
    l.rem = 32'(hi);
    l.ovf = 32'(hi) >= l.dvs;
    l.low = num[31:0];
    l.quo = '0;
    l.neg = diff[32] ^ d[31];
    return l;
  endfunction

  rbst_lanes_t lanes_d, lanes_q;
  rbst_meta_t  meta_d, meta_q;
  logic        valid_q;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic signed [31:0] o, d, lo, hi;
      o  = data_i[32*a +: 32];
      d  = data_i[32*(3+a) +: 32];
      lo = data_i[32*(6+a) +: 32];
      hi = data_i[32*(9+a) +: 32];
      lanes_d[2*a]     = prep(lo, o, d);
      lanes_d[2*a + 1] = prep(hi, o, d);
      meta_d.dzero[a]   = (d == 32'sd0);
      meta_d.in_slab[a] = (o >= lo && o <= hi) || (o >= hi && o <= lo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
      meta_q  <= meta_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;
  assign meta_o  = meta_q;

endmodule

>>> rtl/rbst_div_cell.sv
// One restoring division step for all six lanes; passes state to the next cell.
// Depends on rbst_pkg.
module rbst_div_cell import rbst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  rbst_lanes_t lanes_i,
  input  rbst_meta_t  meta_i,
  output logic        valid_o,
  output rbst_lanes_t lanes_o,
  output rbst_meta_t  meta_o
);

  function automatic rbst_lane_t step(rbst_lane_t l);
    logic [32:0] rem2;
    logic        qbit;
    rbst_lane_t  r;
    r    = l;
    rem2 = {l.rem, l.low[31]};
    qbit = rem2 >= {1'b0, l.dvs};
    r.rem = qbit ? 32'(rem2 - {1'b0, l.dvs}) : rem2[31:0];
    r.quo = {l.quo[30:0], qbit};
    r.low = {l.low[30:0], 1'b0};
    return r;
  endfunction

  rbst_lanes_t lanes_d, lanes_q;
  rbst_meta_t  meta_q;
  logic        valid_q;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lanes_d[i] = step(lanes_i[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
      meta_q  <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;
  assign meta_o  = meta_q;

endmodule

>>> rtl/rbst_back.sv
// Output stages: saturate quotients, order slab crossings, reduce and test hit.
// Depends on rbst_pkg.
module rbst_back import rbst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rbst_lanes_t         lanes_i,
  input  rbst_meta_t          meta_i,
  input  logic [30:0]         limit_i,
  output logic                valid_o,
  output logic [OUT_BITS-1:0] data_o
);

  function automatic logic signed [31:0] sat(rbst_lane_t l);
    logic signed [31:0] t;
    if (!l.neg) begin
      t = (l.ovf || l.quo[31]) ? SAT_MAX : $signed(l.quo);
    end else begin
      t = (l.ovf || l.quo > 32'h8000_0000) ? SAT_MIN : $signed(32'(-l.quo));
    end
    return t;
  endfunction

  logic signed [31:0] near_d [NUM_AXES];
  logic signed [31:0] far_d  [NUM_AXES];
  logic signed [31:0] near_q [NUM_AXES];
  logic signed [31:0] far_q  [NUM_AXES];
  logic               mid_valid_q, out_valid_q;
  logic signed [31:0] entry_d, exit_d;
  logic               hit_d;
  logic [OUT_BITS-1:0] data_d, data_q;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic signed [31:0] t1, t2;
      t1 = sat(lanes_i[2*a]);
      t2 = sat(lanes_i[2*a + 1]);
      if (meta_i.dzero[a]) begin
        near_d[a] = meta_i.in_slab[a] ? SAT_MIN : SAT_MAX;
        far_d[a]  = meta_i.in_slab[a] ? SAT_MAX : SAT_MIN;
      end else begin
        near_d[a] = (t1 < t2) ? t1 : t2;
        far_d[a]  = (t1 < t2) ? t2 : t1;
      end
    end
  end

  always_comb begin
    entry_d = near_q[0];
    exit_d  = far_q[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (near_q[a] > entry_d) entry_d = near_q[a];
      if (far_q[a] < exit_d)   exit_d  = far_q[a];
    end
    hit_d  = (exit_d >= entry_d) && (entry_d < $signed({1'b0, limit_i})) &&
             (exit_d > 32'sd0);
    data_d = {7'b0, exit_d, entry_d, hit_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      mid_valid_q <= valid_i;
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      near_q <= near_d;
      far_q  <= far_d;
      data_q <= data_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/ray_box_slab_test_unit.sv
// Ray versus axis-aligned box slab test, top level.
// Depends on rbst_pkg, rbst_front, rbst_div_cell, rbst_back and the macros header.
//
// Input stream s_axis: one ray and box per transfer, twelve signed fixed-point
// words. Output stream m_axis: hit flag, entry and exit distance per transfer.
// Config channel cfg: writes the distance limit (bits 30:0 of cfg_data_i);
// it is always ready and should be written while the pipe is empty.
// The pipe has one input stage, 32 divider cells (one quotient bit
// each, six divisions side by side), a saturate stage and the output register.
// Throughput is one transfer per cycle while m_axis does not stall.
// A stall on m_axis holds the whole pipe and drops s_axis_tready until the
// pending result is taken. Reset empties the pipe and restores the limit to
// 10000 in the fixed-point format.
`include "ray_box_slab_test_unit_macros.svh"
module ray_box_slab_test_unit import rbst_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // origin x,y,z; direction x,y,z; box_low x,y,z; box_high x,y,z (32 bits each)
  input  logic [IN_BITS-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // hit, entry_distance, exit_distance, 7 zero bits
  output logic [OUT_BITS-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  localparam longint LIMIT_RAW = longint'(10000) << FRACTION_BITS;
  localparam logic [30:0] LIMIT_RESET =
    (LIMIT_RAW > longint'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : 31'(LIMIT_RAW);

  logic        en;
  logic [30:0] limit_q;

  logic        vld   [QUO_BITS+1];
  rbst_lanes_t lanes [QUO_BITS+1];
  rbst_meta_t  meta  [QUO_BITS+1];

  assign en            = !(m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i[30:0];
    end
  end

  rbst_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .valid_o (vld[0]),
    .lanes_o (lanes[0]),
    .meta_o  (meta[0])
  );

  for (genvar c = 0; c < QUO_BITS; c++) begin : g_cell
    rbst_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[c]),
      .lanes_i (lanes[c]),
      .meta_i  (meta[c]),
      .valid_o (vld[c+1]),
      .lanes_o (lanes[c+1]),
      .meta_o  (meta[c+1])
    );
  end

  rbst_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld[QUO_BITS]),
    .lanes_i (lanes[QUO_BITS]),
    .meta_i  (meta[QUO_BITS]),
    .limit_i (limit_q),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata)
  );

  `RBST_ASSERT_IMPL(a_stall_src, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  `RBST_ASSERT_IMPL(a_hit_order, m_axis_tvalid && m_axis_tdata[0],
    $signed(m_axis_tdata[64:33]) >= $signed(m_axis_tdata[32:1]) &&
    $signed(m_axis_tdata[64:33]) > 32'sd0)
  `RBST_ASSERT_NEXT(a_chain_hold, !en, $stable(vld[QUO_BITS]) && $stable(vld[0]))

endmodule

>>> verif/ray_box_slab_test_unit_tb.sv
// Testbench for ray_box_slab_test_unit: random and directed ray/box pairs,
// with a built-in slab-test predictor and an in-order result checker.
// Depends on rbst_pkg and the ray_box_slab_test_unit RTL.
`timescale 1ns / 1ps

typedef struct {
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] lo  [3];
  logic signed [31:0] hi  [3];
} ray_box_t;

typedef struct {
  logic               hit;
  logic signed [31:0] entry_t;
  logic signed [31:0] exit_t;
} slab_result_t;

class slab_scoreboard;
  slab_result_t expected_hits[$];
  logic [30:0]  distance_limit;
  int           errors;
  int           checked;
  int           hits_seen;

  function new();
    distance_limit = 31'd655360000;
    errors = 0;
    checked = 0;
    hits_seen = 0;
  endfunction

  function longint crossing(longint bound, longint org, longint dir);
    longint num;
    longint q;
    num = (bound - org) * (longint'(1) << rbst_pkg::FRACTION_BITS_DEF);
    q = num / dir;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function void note_ray(ray_box_t r);
    longint entry_t, exit_t, o, d, l, h, n, f, t1, t2, a, b;
    slab_result_t e;
    entry_t = -64'sd2147483648;
    exit_t = 64'sd2147483647;
    for (int ax = 0; ax < 3; ax++) begin
      o = r.org[ax];
      d = r.dir[ax];
      l = r.lo[ax];
      h = r.hi[ax];
      if (d == 0) begin
        a = (l < h) ? l : h;
        b = (l < h) ? h : l;
        if (o >= a && o <= b) begin
          n = -64'sd2147483648;
          f = 64'sd2147483647;
        end else begin
          n = 64'sd2147483647;
          f = -64'sd2147483648;
        end
      end else begin
        t1 = crossing(l, o, d);
        t2 = crossing(h, o, d);
        n = (t1 < t2) ? t1 : t2;
        f = (t1 < t2) ? t2 : t1;
      end
      if (n > entry_t) entry_t = n;
      if (f < exit_t) exit_t = f;
    end
    e.hit = (exit_t >= entry_t) && (entry_t < longint'(distance_limit)) && (exit_t > 0);
    e.entry_t = entry_t[31:0];
    e.exit_t = exit_t[31:0];
    expected_hits.push_back(e);
  endfunction

  function void check_result(logic [71:0] data);
    slab_result_t e;
    checked++;
    if (expected_hits.size() == 0) begin
      $error("result transfer with no expectation pending: %h", data);
      errors++;
      return;
    end
    e = expected_hits.pop_front();
    if (data[0]) hits_seen++;
    if (data[0] !== e.hit) begin
      $error("hit: expected %0d, got %0d", e.hit, data[0]);
      errors++;
    end
    if (data[32:1] !== e.entry_t) begin
      $error("entry_distance: expected %0d, got %0d", e.entry_t, $signed(data[32:1]));
      errors++;
    end
    if (data[64:33] !== e.exit_t) begin
      $error("exit_distance: expected %0d, got %0d", e.exit_t, $signed(data[64:33]));
      errors++;
    end
    if (data[71:65] !== 7'd0) begin
      $error("pad bits: expected 0, got %h", data[71:65]);
      errors++;
    end
  endfunction
endclass

module ray_box_slab_test_unit_tb;
  import rbst_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_BITS-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [31:0]         cfg_data_i;

  slab_scoreboard sb;
  int sent;
  int stall_mode;
  int stall_count;

  ray_box_slab_test_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("ray_box_slab_test_unit regression: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // receiver backpressure, switching at random among four ready patterns
  always @(negedge clk_i) begin
    stall_count <= stall_count + 1;
    if (stall_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= (stall_count % 4 != 0);
      default: m_axis_tready <= (stall_count % 40) < 25;
    endcase
  end

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sd0;
      3: return 32'sd1;
      4: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic ray_box_t same_axes(int o, int d, int l, int h);
    ray_box_t r;
    for (int ax = 0; ax < 3; ax++) begin
      r.org[ax] = o;
      r.dir[ax] = d;
      r.lo[ax] = l;
      r.hi[ax] = h;
    end
    return r;
  endfunction

  function automatic ray_box_t random_ray();
    ray_box_t r;
    int kind;
    int c, w;
    kind = $urandom_range(0, 9);
    for (int ax = 0; ax < 3; ax++) begin
      if (kind < 7) begin
        c = $signed($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        w = $urandom_range(0, 32'h0080_0000);
        r.lo[ax] = c - w;
        r.hi[ax] = ($urandom_range(0, 15) == 0) ? c - 2 * w : c + w;
        r.org[ax] = $signed($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
        case ($urandom_range(0, 7))
          0: r.dir[ax] = 0;
          1: r.dir[ax] = $signed($urandom_range(0, 64)) - 32;
          default: r.dir[ax] = $signed($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        endcase
      end else if (kind < 9) begin
        r.org[ax] = $urandom;
        r.dir[ax] = ($urandom_range(0, 5) == 0) ? 32'sd0 : 32'($urandom);
        r.lo[ax] = $urandom;
        r.hi[ax] = $urandom;
      end else begin
        r.org[ax] = pick_extreme();
        r.dir[ax] = pick_extreme();
        r.lo[ax] = pick_extreme();
        r.hi[ax] = pick_extreme();
      end
    end
    return r;
  endfunction

  task automatic send_ray(ray_box_t r);
    logic [IN_BITS-1:0] word;
    for (int ax = 0; ax < 3; ax++) begin
      word[32*ax +: 32]     = r.org[ax];
      word[32*(3+ax) +: 32] = r.dir[ax];
      word[32*(6+ax) +: 32] = r.lo[ax];
      word[32*(9+ax) +: 32] = r.hi[ax];
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_ray(r);
    sent++;
  endtask

  task automatic hold_off(int n);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    hold_off(0);
    while (sb.expected_hits.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.distance_limit = value[30:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int burst;
    int left;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_ray(random_ray());
        left--;
      end
      if ($urandom_range(0, 2) != 0) hold_off($urandom_range(0, 6));
    end
  endtask

  initial begin
    ray_box_t r;
    logic [31:0] limits [6];
    sb = new();
    sent = 0;
    stall_mode = 0;
    stall_count = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b1;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // basic hit, then a box behind the ray
    send_ray(same_axes(0, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000));
    send_ray(same_axes(0, 32'h0001_0000, -32'h0004_0000, -32'h0002_0000));
    // inverted box, negative direction
    send_ray(same_axes(0, -32'h0001_0000, -32'h0002_0000, -32'h0004_0000));
    // zero direction inside, on the boundary and outside the slab
    r = same_axes(32'h0001_0000, 32'h0001_0000, 0, 32'h0004_0000);
    r.dir[1] = 0;
    send_ray(r);
    r.org[1] = 32'h0004_0000;
    send_ray(r);
    r.org[1] = 32'h0005_0000;
    send_ray(r);
    send_ray(same_axes(5, 0, 0, 10));
    send_ray(same_axes(0, 0, 0, 0));
    // saturation in both directions
    send_ray(same_axes(32'sh8000_0000, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_ray(same_axes(32'sh7FFF_FFFF, 1, 32'sh8000_0000, 32'sh8000_0000));
    send_ray(same_axes(32'sh7FFF_FFFF, -1, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_ray(same_axes(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_ray(same_axes(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
    // exit exactly at the origin, entry exactly at and just below the limit
    send_ray(same_axes(0, 32'h0001_0000, -32'h0004_0000, 0));
    send_ray(same_axes(0, 32'h0001_0000, 32'h2710_0000, 32'h2800_0000));
    send_ray(same_axes(0, 32'h0001_0000, 32'h270F_0000, 32'h2800_0000));
    send_ray(same_axes(-1, -1, 32'sh8000_0000, 32'sh7FFF_FFFF));
    drain();

    limits[0] = 32'h0000_0000;
    limits[1] = 32'hFFFF_FFFF;
    limits[2] = 32'h7FFF_FFFF;
    limits[3] = 32'h8000_0001;
    limits[4] = $urandom;
    limits[5] = 32'd655360000;
    random_phase(400);
    drain();
    foreach (limits[k]) begin
      write_limit(limits[k]);
      if (k == 1) send_ray(same_axes(0, 32'h0001_0000, 32'h7000_0000, 32'h7FFF_FFFF));
      random_phase(250);
      drain();
    end

    $display("covered %0d ray/box transfers, %0d results checked, %0d hits,",
             sent, sb.checked, sb.hits_seen);
    $display("across 7 distance limit settings including both extremes");
    if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
      $display("ray_box_slab_test_unit regression: pass");
    end else begin
      $display("ray_box_slab_test_unit regression: fail");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/rbst_pkg.sv
rtl/rbst_front.sv
rtl/rbst_div_cell.sv
rtl/rbst_back.sv
rtl/ray_box_slab_test_unit.sv
verif/ray_box_slab_test_unit_tb.sv
